@@ rtl/gcfd_pkg.sv @@
// shared types and constants of the grid code frame decoder
`default_nettype none

package gcfd_pkg;

  localparam int unsigned SEQ_W       = 16;
  localparam int unsigned COPY_BITS   = 16;
  localparam int unsigned COPY_SHIFT  = $clog2(COPY_BITS);
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_BLACK_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_LIMIT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SEQUENCE  = 2'd2;

  localparam logic [7:0]       THRESHOLD_RESET  = 8'd128;
  localparam logic [3:0]       MISS_LIMIT_RESET = 4'd10;
  localparam logic [SEQ_W-1:0] SEQUENCE_RESET   = '0;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic             has_byte;
    logic [7:0]       data_byte;
    logic             has_status;
    logic             accepted;
    logic [SEQ_W-1:0] next_seq;
  } entry_t;

endpackage

`default_nettype wire

@@ rtl/gcfd_front.sv @@
// front end: cell classification, header match, byte packing, sequence bookkeeping
`default_nettype none

module gcfd_front
  import gcfd_pkg::*;
#(
  parameter int unsigned GRID_SIZE     = 64,
  parameter int unsigned HEADER_COPIES = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cell_valid,
  input  wire logic [7:0]            cell_level,
  input  wire logic                  queue_full,
  output logic                       cell_stall,
  output logic                       push,
  output entry_t                     push_entry,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned CW = $clog2(GRID_SIZE);
  localparam logic [CW-1:0] LAST = CW'(GRID_SIZE - 1);

  logic [7:0]       threshold;
  logic [3:0]       miss_limit;
  logic [SEQ_W-1:0] expected;
  logic [3:0]       miss_count;
  logic [CW-1:0]    column;
  logic [CW-1:0]    row;
  logic             frame_match;
  logic [7:0]       byte_shift;
  logic [COPY_BITS-1:0] copies [HEADER_COPIES];

  logic                 accept;
  logic                 cell_bit;
  logic                 row_first;
  logic                 col_first;
  logic                 frame_end;
  logic [7:0]           byte_shift_next;
  logic [COPY_BITS-1:0] copies_next [HEADER_COPIES];
  logic                 match_any;
  logic                 frame_match_next;
  logic [4:0]           miss_inc;
  logic                 advance;
  logic [SEQ_W-1:0]     expected_next;
  logic [3:0]           miss_count_next;
  logic                 byte_ready;

  assign cell_stall = queue_full;
  assign accept     = cell_valid && !cell_stall;
  assign cell_bit   = cell_level < threshold;
  assign row_first  = row == '0;
  assign col_first  = column == '0;
  assign frame_end  = (row == LAST) && (column == LAST);

  always_comb begin
    logic [7:0]           shift_base;
    logic [COPY_BITS-1:0] copy_base;
    shift_base = col_first ? 8'd0 : byte_shift;
    byte_shift_next = {shift_base[6:0], cell_bit};
    match_any = 1'b0;
    for (int k = 0; k < HEADER_COPIES; k++) begin
      copy_base = (row_first && col_first) ? '0 : copies[k];
      if (row_first && ((column >> COPY_SHIFT) == CW'(k))) begin
        copies_next[k] = {copy_base[COPY_BITS-2:0], cell_bit};
      end else begin
        copies_next[k] = copy_base;
      end
      if (copies_next[k] == expected) begin
        match_any = 1'b1;
      end
    end
  end

  always_comb begin
    frame_match_next = frame_match;
    if (row_first && col_first) begin
      frame_match_next = 1'b0;
    end
    if (row_first && column == LAST) begin
      frame_match_next = match_any;
    end
  end

  assign miss_inc        = {1'b0, miss_count} + 5'd1;
  assign advance         = frame_match || (miss_inc >= {1'b0, miss_limit});
  assign expected_next   = advance ? expected + SEQ_W'(1) : expected;
  assign miss_count_next = advance ? 4'd0 : miss_inc[3:0];
  assign byte_ready      = !row_first && (column[2:0] == 3'b111) && frame_match;

  always_comb begin
    push_entry.has_byte   = byte_ready;
    push_entry.data_byte  = byte_shift_next;
    push_entry.has_status = frame_end;
    push_entry.accepted   = frame_match;
    push_entry.next_seq   = expected_next;
  end

  assign push = accept && (byte_ready || frame_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold   <= THRESHOLD_RESET;
      miss_limit  <= MISS_LIMIT_RESET;
      expected    <= SEQUENCE_RESET;
      miss_count  <= '0;
      column      <= '0;
      row         <= '0;
      frame_match <= 1'b0;
      byte_shift  <= '0;
      for (int k = 0; k < HEADER_COPIES; k++) begin
        copies[k] <= '0;
      end
    end else begin
      if (accept) begin
        byte_shift  <= byte_shift_next;
        frame_match <= frame_match_next;
        for (int k = 0; k < HEADER_COPIES; k++) begin
          copies[k] <= copies_next[k];
        end
        if (frame_end) begin
          expected   <= expected_next;
          miss_count <= miss_count_next;
        end
        if (column == LAST) begin
          column <= '0;
          row    <= (row == LAST) ? '0 : row + CW'(1);
        end else begin
          column <= column + CW'(1);
        end
      end
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_BLACK_THRESHOLD: threshold  <= cfg_data[7:0];
          CFG_MISS_LIMIT:      miss_limit <= cfg_data[3:0];
          CFG_START_SEQUENCE:  expected   <= cfg_data[SEQ_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/gcfd_queue.sv @@
// short queue of classified work between front and back
`default_nettype none

module gcfd_queue
  import gcfd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  entry_t    push_entry,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output entry_t    head
);

  entry_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full       = count == QCNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + QCNT_W'(1))
    else $error("queue count lost a push");

endmodule

`default_nettype wire

@@ rtl/gcfd_back.sv @@
// back end: expands queued work into byte and status transfers
`default_nettype none

module gcfd_back
  import gcfd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        head_valid,
  input  entry_t           head,
  output logic             pop,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic             result_kind,
  output logic [7:0]       data_byte,
  output logic             frame_accepted,
  output logic [SEQ_W-1:0] next_sequence,
  output logic             last_of_run
);

  logic phase;
  logic load;
  logic emit_byte;

  assign load      = !result_valid || !result_stall;
  assign emit_byte = !phase && head.has_byte;
  assign pop       = load && head_valid && (!emit_byte || !head.has_status);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= 1'b0;
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= head_valid;
      if (head_valid) begin
        if (emit_byte) begin
          phase <= head.has_status;
        end else begin
          phase <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      if (emit_byte) begin
        result_kind    <= KIND_DATA;
        data_byte      <= head.data_byte;
        frame_accepted <= 1'b0;
        next_sequence  <= '0;
        last_of_run    <= !head.has_status;
      end else begin
        result_kind    <= KIND_STATUS;
        data_byte      <= '0;
        frame_accepted <= head.accepted;
        next_sequence  <= head.next_seq;
        last_of_run    <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/grid_code_frame_decoder.sv @@
// top level of the grid code frame decoder
//
//   channel   signals                               transfer when
//   cell      cell_valid cell_stall cell_level      cell_valid && !cell_stall
//   result    result_valid result_stall + fields    result_valid && !result_stall
//   cfg       cfg_valid cfg_ready cfg_index cfg_data cfg_valid && cfg_ready
//
// one cell per cycle when not stalled; a result is queued, then registered
// last cell of a frame with a byte due: two results, one per unstalled cycle
// four-entry work queue; cell_stall rises only when it is full
// rst synchronous: registers to reset values, queue and output emptied
`default_nettype none

module grid_code_frame_decoder
  import gcfd_pkg::*;
#(
  parameter int unsigned GRID_SIZE     = 64,
  parameter int unsigned HEADER_COPIES = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cell_valid,
  output logic                       cell_stall,
  input  wire logic [7:0]            cell_level,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output logic                       result_kind,
  output logic [7:0]                 data_byte,
  output logic                       frame_accepted,
  output logic [SEQ_W-1:0]           next_sequence,
  output logic                       last_of_run,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic   queue_full;
  logic   push;
  entry_t push_entry;
  logic   pop;
  logic   head_valid;
  entry_t head;

  assign cfg_ready = 1'b1;

  gcfd_front #(
    .GRID_SIZE     (GRID_SIZE),
    .HEADER_COPIES (HEADER_COPIES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cell_valid (cell_valid),
    .cell_level (cell_level),
    .queue_full (queue_full),
    .cell_stall (cell_stall),
    .push       (push),
    .push_entry (push_entry),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  gcfd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  gcfd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .result_kind    (result_kind),
    .data_byte      (data_byte),
    .frame_accepted (frame_accepted),
    .next_sequence  (next_sequence),
    .last_of_run    (last_of_run)
  );

endmodule

`default_nettype wire
